/* hdl/lrpa_pkg.sv */
// Shared types and constants for the line rasterizer pixel address block.
`default_nettype none

package lrpa_pkg;

    // Command codes carried in the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_FRAME_BASE   = 2'd2
    } t_cfg_reg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int SIZE_BITS      = 12;
    localparam int PIX_BITS       = 11;
    localparam int ADDR_BITS      = 32;
    localparam int OUT_TDATA_BITS = 56;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - 2 * PIX_BITS - ADDR_BITS;

    localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 12'd480;

    // Largest legal coordinate on one axis: size-1, floored at 0, capped at 2047
    function automatic logic [PIX_BITS-1:0] clamp_bound(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] size_m1;
        size_m1 = (size == '0) ? '0 : size - 1'b1;
        if (size_m1[SIZE_BITS-1])
            return '1;
        return size_m1[PIX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/line_rasterizer_pixel_address.sv */
// Bresenham line rasterizer emitting clamped pixels and frame-buffer byte addresses.
//
// Channel   Dir  Handshake                    Contents
// s_axis    in   s_axis_tvalid/tready         tuser: cmd; tdata: start_x, start_y, end_x_in,
//                                             end_y_in (COORD_BITS each, low bits first)
// m_axis    out  m_axis_tvalid/tready         tlast: last; tdata: pixel_x, pixel_y,
//                                             byte_address, 2 zero pad bits
// cfg       in   i_cfg_we                     0 frame_width, 1 frame_height, 2 frame_base
//
// One item per clock unless the output stalls. A step item is turned into its pixel
// in the cycle it is accepted: clamp, a 12x11 multiply and two 32-bit adds sit
// between the line state and the output register, so a pixel appears in the cycle
// after its step item. Load items and steps while idle give no pixel.
// The single output register stalls the input only while it holds an untaken pixel.
// Reset (synchronous, active low) clears the line state, sets the frame registers to
// 640 x 480 at base 0 and empties the output register.
`default_nettype none

module line_rasterizer_pixel_address #(
    parameter int COORD_BITS = 12,
    localparam int InTdataW  = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // tdata, low bit up: start_x, start_y, end_x_in, end_y_in, zero pad
    input  wire logic [InTdataW-1:0]                  s_axis_tdata,
    // tuser: cmd
    input  wire logic                                 s_axis_tuser,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata, low bit up: pixel_x, pixel_y, byte_address, zero pad
    output logic [lrpa_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,
    output logic                                      m_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lrpa_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [lrpa_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);

    localparam int CurW  = COORD_BITS + 1;  // headroom so a position never wraps
    localparam int SpanW = COORD_BITS;
    localparam int ErrW  = COORD_BITS + 4;
    localparam int PixW  = lrpa_pkg::PIX_BITS;
    localparam int SizeW = lrpa_pkg::SIZE_BITS;
    localparam int AddrW = lrpa_pkg::ADDR_BITS;
    localparam int ProdW = SizeW + PixW;

    // ---------------- configuration ----------------
    logic [SizeW-1:0] r_frame_width, r_frame_height;
    logic [AddrW-1:0] r_frame_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lrpa_pkg::RESET_WIDTH;
            r_frame_height <= lrpa_pkg::RESET_HEIGHT;
            r_frame_base   <= '0;
        end else if (i_cfg_we) begin
            case (lrpa_pkg::t_cfg_reg'(i_cfg_index))
                lrpa_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[SizeW-1:0];
                lrpa_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[SizeW-1:0];
                lrpa_pkg::REG_FRAME_BASE:   r_frame_base   <= i_cfg_wdata[AddrW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic w_in_acc, w_load, w_step;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_in_acc && (s_axis_tuser == lrpa_pkg::CMD_LOAD);

    // ---------------- line state ----------------
    logic signed [CurW-1:0]       r_cur_x, r_cur_y;
    logic signed [COORD_BITS-1:0] r_goal_x, r_goal_y;
    logic                         r_dir_x_neg, r_dir_y_neg;
    logic [SpanW-1:0]             r_span_x, r_span_y;
    logic signed [ErrW-1:0]       r_err;
    logic                         r_x_major, r_active;

    assign w_step = w_in_acc && (s_axis_tuser == lrpa_pkg::CMD_STEP) && r_active;

    // Load set-up
    logic signed [COORD_BITS-1:0] w_x1, w_y1, w_x2, w_y2;
    logic signed [CurW-1:0]       w_dx, w_dy;
    logic                         w_x_gt, w_y_gt, w_ld_x_major;
    logic [SpanW-1:0]             w_sx, w_sy;
    logic signed [ErrW-1:0]       w_ld_err;

    always_comb begin
        w_x1 = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
        w_y1 = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
        w_x2 = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        w_y2 = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        w_dx = CurW'(w_x2) - CurW'(w_x1);
        w_dy = CurW'(w_y2) - CurW'(w_y1);
        w_x_gt = w_x2 > w_x1;
        w_y_gt = w_y2 > w_y1;
        w_sx = w_x_gt ? w_dx[SpanW-1:0] : SpanW'(-w_dx);
        w_sy = w_y_gt ? w_dy[SpanW-1:0] : SpanW'(-w_dy);
        w_ld_x_major = w_sx > w_sy;
        if (w_ld_x_major)
            w_ld_err = signed'({2'b0, w_sy, 1'b0}) - signed'({3'b0, w_sx});
        else
            w_ld_err = signed'({2'b0, w_sx, 1'b0}) - signed'({3'b0, w_sy});
    end

    // Bresenham step
    logic                   w_done, w_err_pos, w_mv_x, w_mv_y;
    logic [SpanW-1:0]       w_span_maj, w_span_min;
    logic signed [ErrW-1:0] w_err_add, w_err_next;
    logic signed [CurW-1:0] w_cur_x_next, w_cur_y_next;

    always_comb begin
        w_done = r_x_major ? (r_cur_x == CurW'(r_goal_x)) : (r_cur_y == CurW'(r_goal_y));
        w_span_maj = r_x_major ? r_span_x : r_span_y;
        w_span_min = r_x_major ? r_span_y : r_span_x;
        w_err_add  = r_err + signed'({2'b0, w_span_min, 1'b0});
        w_err_pos  = w_err_add > 0;
        w_err_next = w_err_pos ? w_err_add - signed'({2'b0, w_span_maj, 1'b0}) : w_err_add;
        w_mv_x = r_x_major || w_err_pos;
        w_mv_y = !r_x_major || w_err_pos;
        w_cur_x_next = !w_mv_x ? r_cur_x : (r_dir_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1);
        w_cur_y_next = !w_mv_y ? r_cur_y : (r_dir_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_dir_x_neg <= 1'b0;
            r_dir_y_neg <= 1'b0;
            r_span_x    <= '0;
            r_span_y    <= '0;
            r_err       <= '0;
            r_x_major   <= 1'b0;
            r_active    <= 1'b0;
        end else if (w_load) begin
            // a load drops any line in progress
            r_cur_x     <= CurW'(w_x1);
            r_cur_y     <= CurW'(w_y1);
            r_goal_x    <= w_x2;
            r_goal_y    <= w_y2;
            r_dir_x_neg <= !w_x_gt;
            r_dir_y_neg <= !w_y_gt;
            r_span_x    <= w_sx;
            r_span_y    <= w_sy;
            r_err       <= w_ld_err;
            r_x_major   <= w_ld_x_major;
            r_active    <= 1'b1;
        end else if (w_step) begin
            if (w_done) begin
                r_active <= 1'b0;
            end else begin
                r_cur_x <= w_cur_x_next;
                r_cur_y <= w_cur_y_next;
                r_err   <= w_err_next;
            end
        end
    end

    // ---------------- pixel and address ----------------
    logic [PixW-1:0]  w_hi_x, w_hi_y, w_px, w_py;
    logic [ProdW-1:0] w_prod;
    logic [AddrW-1:0] w_index, w_addr;

    always_comb begin
        w_hi_x = lrpa_pkg::clamp_bound(r_frame_width);
        w_hi_y = lrpa_pkg::clamp_bound(r_frame_height);
        if (r_cur_x[CurW-1])
            w_px = '0;
        else if (32'(r_cur_x[CurW-2:0]) > 32'(w_hi_x))
            w_px = w_hi_x;
        else
            w_px = PixW'(r_cur_x[CurW-2:0]);
        if (r_cur_y[CurW-1])
            w_py = '0;
        else if (32'(r_cur_y[CurW-2:0]) > 32'(w_hi_y))
            w_py = w_hi_y;
        else
            w_py = PixW'(r_cur_y[CurW-2:0]);
        // row stride is the raw width, not the clamp bound
        w_prod  = ProdW'(r_frame_width) * ProdW'(w_py);
        w_index = AddrW'(w_prod) + AddrW'(w_px);
        w_addr  = r_frame_base + {w_index[AddrW-3:0], 2'b00};
    end

    // ---------------- output register ----------------
    logic [PixW-1:0]  r_out_x, r_out_y;
    logic [AddrW-1:0] r_out_addr;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_step)
            r_out_valid <= 1'b1;
        else if (m_axis_tready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_x    <= w_px;
            r_out_y    <= w_py;
            r_out_addr <= w_addr;
            r_out_last <= w_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{lrpa_pkg::OUT_PAD_BITS{1'b0}}, r_out_addr, r_out_y, r_out_x};

    // ---------------- assertions ----------------
    // the line only ends by emitting its end point
    a_end_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) |-> (r_out_valid && r_out_last))
        else $error("line went idle without a last pixel");

    // major axis agrees with the spans
    a_major_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_major ? (r_span_x > r_span_y) : (r_span_x <= r_span_y))
        else $error("major axis inconsistent with spans");

    // a load always arms the line
    a_load_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_active)
        else $error("load did not start a line");

    // a stalled pixel freezes the walk
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=>
            ($stable(r_cur_x) && $stable(r_cur_y) && $stable(r_err)))
        else $error("line advanced while output stalled");

endmodule

`default_nettype wire
